// ===== src/dcf_pkg.sv =====
`default_nettype none

package dcf_pkg;

    localparam int X_W = 7;
    localparam int Y_W = 6;
    localparam int COLS_W = 8;
    localparam int ROWS_W = 7;
    localparam int CFG_DATA_W = 8;

    localparam logic [COLS_W-1:0] ACTIVE_COLS_RESET = 8'd128;
    localparam logic [ROWS_W-1:0] ACTIVE_ROWS_RESET = 7'd64;

    localparam logic [1:0] CMD_WRITE_PIXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE_BG    = 2'd1;
    localparam logic [1:0] CMD_REMOVE      = 2'd2;
    localparam logic [1:0] CMD_REFRESH     = 2'd3;

    localparam logic REG_ACTIVE_COLS = 1'b0;
    localparam logic REG_ACTIVE_ROWS = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t bg_bot;
        pixel_t bg_top;
        pixel_t px_bot;
        pixel_t px_top;
        logic   mark_bot;
        logic   mark_top;
    } dcf_entry_t;

    localparam dcf_entry_t ENTRY_RESET = '{
        bg_bot:   '0,
        bg_top:   '0,
        px_bot:   '0,
        px_top:   '0,
        mark_bot: 1'b1,
        mark_top: 1'b1
    };

    typedef struct packed {
        logic [1:0]     cmd;
        logic [X_W-1:0] col;
        logic [Y_W-1:0] row_top;
        logic           half;
        logic           item_ok;
        logic           bot_ok;
        pixel_t         colour;
    } dcf_item_t;

    typedef struct packed {
        logic [X_W-1:0] col;
        logic [Y_W-1:0] row;
        pixel_t         top;
        pixel_t         bottom;
        logic           half_block;
    } dcf_result_t;

endpackage

`default_nettype wire

// ===== src/dirty_cell_framebuffer.sv =====
`default_nettype none

// Dirty-tracked RGB frame store for a half-block display. Pixels are kept in
// vertical pairs, one memory entry per pair holding both pixel colours, both
// background colours and both modified marks; entry address is
// column * ceil(MAX_ROWS/2) + row/2. For every item the pair entry is read in
// the accept cycle and modified and written back in the write-back state,
// through the single read and write port of the pair memory. A refresh
// result waits in an output register, and the item after it is accepted
// while that result is not yet taken; a refresh that finds the output
// register still full holds in its write-back cycle. After reset the block
// runs a clearing pass over MAX_COLS * ceil(MAX_ROWS/2) entries (4096 at the
// default size) that sets every pixel and background to black and every mark
// to modified; input stays stalled until it is done, configuration writes are
// taken at any time.

module dirty_cell_framebuffer
    import dcf_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_write_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            cmd,
    input  wire logic [X_W-1:0]        x,
    input  wire logic [Y_W-1:0]        y,
    input  wire logic [7:0]            red,
    input  wire logic [7:0]            green,
    input  wire logic [7:0]            blue,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [X_W-1:0]             out_col,
    output logic [Y_W-1:0]             out_row,
    output logic [7:0]                 top_red,
    output logic [7:0]                 top_green,
    output logic [7:0]                 top_blue,
    output logic [7:0]                 bottom_red,
    output logic [7:0]                 bottom_green,
    output logic [7:0]                 bottom_blue,
    output logic                       half_block
);

    localparam int PAIRS  = (MAX_ROWS + 1) / 2;
    localparam int DEPTH  = MAX_COLS * PAIRS;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_MODIFY = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [COLS_W-1:0]   active_cols_reg, active_cols_next;
    logic [ROWS_W-1:0]   active_rows_reg, active_rows_next;
    dcf_item_t           item_reg, item_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                out_valid_reg, out_valid_next;
    dcf_result_t         result_reg, result_next;

    logic                in_accept;
    logic [Y_W-1:0]      row_pix;
    logic [Y_W-1:0]      row_top;
    logic [Y_W-1:0]      row_bot;
    logic                col_ok;
    logic                row_ok;
    logic                bot_row_ok;
    logic [ADDR_W-1:0]   rd_addr;

    dcf_entry_t          rd_entry;
    dcf_entry_t          mod_entry;
    logic                mod_we;
    logic                mod_emit;
    dcf_result_t         mod_result;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_wr_addr;
    dcf_entry_t          ram_wr_data;
    logic                out_free;
    logic                proceed;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid & ~in_stall;

    assign row_top = {y[Y_W-1:1], 1'b0};
    assign row_bot = {y[Y_W-1:1], 1'b1};
    assign row_pix = (cmd == CMD_REFRESH) ? row_top : y;

    assign col_ok = ({1'b0, x} < active_cols_reg) && (32'(x) < 32'(MAX_COLS));
    assign row_ok = ({1'b0, row_pix} < active_rows_reg) && (32'(row_pix) < 32'(MAX_ROWS));
    assign bot_row_ok = ({1'b0, row_bot} < active_rows_reg) &&
                        (32'(row_bot) < 32'(MAX_ROWS));

    assign rd_addr = ADDR_W'(32'(x) * 32'(PAIRS) + 32'(y[Y_W-1:1]));

    always_comb
    begin
        item_next         = item_reg;
        addr_next         = addr_reg;
        if (in_accept)
        begin
            item_next.cmd     = cmd;
            item_next.col     = x;
            item_next.row_top = row_top;
            item_next.half    = y[0];
            item_next.item_ok = col_ok & row_ok;
            item_next.bot_ok  = col_ok & bot_row_ok;
            item_next.colour  = '{red: red, green: green, blue: blue};
            addr_next         = rd_addr;
        end
    end

    dcf_ram #(
        .WIDTH ($bits(dcf_entry_t)),
        .DEPTH (DEPTH)
    ) u_pair_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    dcf_modify u_modify (
        .item      (item_reg),
        .entry_in  (rd_entry),
        .entry_out (mod_entry),
        .write_en  (mod_we),
        .emit      (mod_emit),
        .result    (mod_result)
    );

    assign out_free = ~out_valid_reg | ~out_stall;
    assign proceed  = (state_reg == S_MODIFY) & (~mod_emit | out_free);

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = mod_entry;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = ENTRY_RESET;
            end
            S_MODIFY:
            begin
                ram_we = proceed & mod_we;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                if (proceed)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        result_next    = result_reg;
        if (proceed && mod_emit)
        begin
            out_valid_next = 1'b1;
            result_next    = mod_result;
        end
    end

    always_comb
    begin
        active_cols_next = active_cols_reg;
        active_rows_next = active_rows_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ACTIVE_COLS: active_cols_next = cfg_data;
                REG_ACTIVE_ROWS: active_rows_next = cfg_data[ROWS_W-1:0];
                default:         active_cols_next = active_cols_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            active_cols_reg <= ACTIVE_COLS_RESET;
            active_rows_reg <= ACTIVE_ROWS_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            active_cols_reg <= active_cols_next;
            active_rows_reg <= active_rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_col      = result_reg.col;
    assign out_row      = result_reg.row;
    assign top_red      = result_reg.top.red;
    assign top_green    = result_reg.top.green;
    assign top_blue     = result_reg.top.blue;
    assign bottom_red   = result_reg.bottom.red;
    assign bottom_green = result_reg.bottom.green;
    assign bottom_blue  = result_reg.bottom.blue;
    assign half_block   = result_reg.half_block;

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("pair memory written while idle");

    a_accept_to_modify: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_MODIFY)
        else $error("accepted beat not followed by write-back cycle");

    a_result_from_modify: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_MODIFY))
        else $error("result raised outside write-back cycle");

    a_refresh_clears_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MODIFY && item_reg.cmd == CMD_REFRESH && ram_we)
        |-> !ram_wr_data.mark_top)
        else $error("refresh write-back left top mark set");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && mod_emit) |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

// ===== src/dcf_ram.sv =====
`default_nettype none

module dcf_ram #(
    parameter int WIDTH = 98,
    parameter int DEPTH = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/dcf_modify.sv =====
`default_nettype none

module dcf_modify
    import dcf_pkg::*;
(
    input  wire dcf_item_t   item,
    input  wire dcf_entry_t  entry_in,
    output dcf_entry_t       entry_out,
    output logic             write_en,
    output logic             emit,
    output dcf_result_t      result
);

    pixel_t bottom;
    logic   bot_mod;

    always_comb
    begin
        bottom  = item.bot_ok ? entry_in.px_bot : '0;
        bot_mod = item.bot_ok & entry_in.mark_bot;

        entry_out = entry_in;
        write_en  = 1'b0;
        emit      = 1'b0;

        case (item.cmd)
            CMD_WRITE_PIXEL:
            begin
                write_en = item.item_ok;
                if (item.half)
                begin
                    entry_out.px_bot   = item.colour;
                    entry_out.mark_bot = 1'b1;
                end
                else
                begin
                    entry_out.px_top   = item.colour;
                    entry_out.mark_top = 1'b1;
                end
            end
            CMD_WRITE_BG:
            begin
                write_en = item.item_ok;
                if (item.half)
                begin
                    entry_out.bg_bot = item.colour;
                end
                else
                begin
                    entry_out.bg_top = item.colour;
                end
            end
            CMD_REMOVE:
            begin
                write_en = item.item_ok;
                if (item.half)
                begin
                    entry_out.px_bot   = entry_in.bg_bot;
                    entry_out.mark_bot = 1'b1;
                end
                else
                begin
                    entry_out.px_top   = entry_in.bg_top;
                    entry_out.mark_top = 1'b1;
                end
            end
            default:
            begin
                emit     = item.item_ok & (entry_in.mark_top | bot_mod);
                write_en = emit;
                entry_out.mark_top = 1'b0;
                if (item.bot_ok)
                begin
                    entry_out.mark_bot = 1'b0;
                end
            end
        endcase

        result.col        = item.col;
        result.row        = item.row_top;
        result.top        = entry_in.px_top;
        result.bottom     = bottom;
        result.half_block = (entry_in.px_top != bottom);
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import dcf_pkg::*;

    localparam int SCREEN_COLS = 128;
    localparam int SCREEN_ROWS = 64;
    localparam int FRAME_DEPTH = SCREEN_COLS * SCREEN_ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int REPORT_MAX = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic                  cfg_index = REG_ACTIVE_COLS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            cmd = CMD_WRITE_PIXEL;
    logic [X_W-1:0]        x = '0;
    logic [Y_W-1:0]        y = '0;
    logic [7:0]            red = '0;
    logic [7:0]            green = '0;
    logic [7:0]            blue = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [X_W-1:0]        out_col;
    logic [Y_W-1:0]        out_row;
    logic [7:0]            top_red;
    logic [7:0]            top_green;
    logic [7:0]            top_blue;
    logic [7:0]            bottom_red;
    logic [7:0]            bottom_green;
    logic [7:0]            bottom_blue;
    logic                  half_block;

    wire in_beat = in_valid && !in_stall;
    wire out_beat = out_valid && !out_stall;

    // frame predictor state
    pixel_t      frame_px [FRAME_DEPTH];
    pixel_t      frame_bg [FRAME_DEPTH];
    bit          frame_mark [FRAME_DEPTH];
    int          act_cols;
    int          act_rows;
    dcf_result_t due_cells [$];

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int hold_cycles = 0;
    int items_sent = 0;
    int cells_seen = 0;
    int bad_fields = 0;
    int screens_set = 0;

    pixel_t palette [4] = '{24'h000000, 24'hFFFFFF, 24'h5A3CC3, 24'hA5C33C};

    dirty_cell_framebuffer #(
        .MAX_COLS(SCREEN_COLS),
        .MAX_ROWS(SCREEN_ROWS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .x(x),
        .y(y),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_col(out_col),
        .out_row(out_row),
        .top_red(top_red),
        .top_green(top_green),
        .top_blue(top_blue),
        .bottom_red(bottom_red),
        .bottom_green(bottom_green),
        .bottom_blue(bottom_blue),
        .half_block(half_block)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit on_screen(int col, int row);
        return col < act_cols && col < SCREEN_COLS && row < act_rows && row < SCREEN_ROWS;
    endfunction

    // returns whether the item touched the frame
    function automatic bit apply_to_frame(logic [1:0] c, logic [X_W-1:0] px,
                                          logic [Y_W-1:0] py, pixel_t colour);
        int          row;
        int          top_a;
        bit          bot_in;
        pixel_t      top_px;
        pixel_t      bot_px;
        dcf_result_t pair_res;
        row = (c == CMD_REFRESH) ? int'(py & 6'h3E) : int'(py);
        if (!on_screen(px, row))
            return 1'b0;
        top_a = px * SCREEN_ROWS + row;
        case (c)
            CMD_WRITE_PIXEL:
            begin
                frame_px[top_a] = colour;
                frame_mark[top_a] = 1'b1;
            end
            CMD_WRITE_BG:
                frame_bg[top_a] = colour;
            CMD_REMOVE:
            begin
                frame_px[top_a] = frame_bg[top_a];
                frame_mark[top_a] = 1'b1;
            end
            default:
            begin
                bot_in = on_screen(px, row + 1);
                top_px = frame_px[top_a];
                bot_px = bot_in ? frame_px[top_a + 1] : pixel_t'('0);
                if (frame_mark[top_a] || (bot_in && frame_mark[top_a + 1]))
                begin
                    frame_mark[top_a] = 1'b0;
                    if (bot_in)
                        frame_mark[top_a + 1] = 1'b0;
                    pair_res.col = px;
                    pair_res.row = Y_W'(row);
                    pair_res.top = top_px;
                    pair_res.bottom = bot_px;
                    pair_res.half_block = (top_px != bot_px);
                    due_cells.push_back(pair_res);
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            bad_fields++;
            if (bad_fields <= REPORT_MAX)
                $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    function automatic void check_cell();
        dcf_result_t want;
        cells_seen++;
        if (due_cells.size() == 0)
        begin
            bad_fields++;
            if (bad_fields <= REPORT_MAX)
                $display("%0t: unexpected cell pair at col %0d row %0d",
                         $realtime, out_col, out_row);
            return;
        end
        want = due_cells.pop_front();
        check_field("out_col", want.col, out_col);
        check_field("out_row", want.row, out_row);
        check_field("top_red", want.top.red, top_red);
        check_field("top_green", want.top.green, top_green);
        check_field("top_blue", want.top.blue, top_blue);
        check_field("bottom_red", want.bottom.red, bottom_red);
        check_field("bottom_green", want.bottom.green, bottom_green);
        check_field("bottom_blue", want.bottom.blue, bottom_blue);
        check_field("half_block", want.half_block, half_block);
    endfunction

    // result side: random stall per beat while sink_idle is set, long hold-off on request
    initial
    begin
        int wait_cycles;
        wait (rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else
            begin
                wait_cycles = sink_idle ? $urandom_range(0, 16) : 0;
                if (wait_cycles > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            check_cell();
        end
    end

    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if (in_beat || out_beat)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("timeout with %0d cell pairs outstanding", due_cells.size());
        $display("[dirty_cell_framebuffer] ERROR");
        $finish;
    end

    task automatic send_item(logic [1:0] c, int px, int py, pixel_t colour,
                             output bit touched);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        x <= px[X_W-1:0];
        y <= py[Y_W-1:0];
        red <= colour.red;
        green <= colour.green;
        blue <= colour.blue;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        touched = apply_to_frame(c, px[X_W-1:0], py[Y_W-1:0], colour);
        items_sent++;
    endtask

    task automatic send(logic [1:0] c, int px, int py, pixel_t colour);
        bit touched;
        send_item(c, px, py, colour, touched);
    endtask

    task automatic drain_cells();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_screen(logic [7:0] cols, logic [7:0] rows);
        drain_cells();
        repeat (8) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_ACTIVE_COLS;
        cfg_data <= cols;
        @(posedge clk);
        cfg_index <= REG_ACTIVE_ROWS;
        cfg_data <= rows;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        act_cols = cols;
        act_rows = rows[ROWS_W-1:0];
        screens_set++;
    endtask

    function automatic int pick_coord(int active, int full, int window, int mode);
        int span;
        span = (active < full) ? active : full;
        if (mode == 0 && span > window)
            span = window;
        if (mode == 2 || span == 0)
            return $urandom_range(0, full - 1);
        return $urandom_range(0, span - 1);
    endfunction

    task automatic test_after_reset();
        send(CMD_REFRESH, 0, 0, 24'h000000);
        send(CMD_REFRESH, 127, 63, 24'hFFFFFF);
        send(CMD_REFRESH, 0, 0, 24'h000000);
    endtask

    task automatic test_pixel_ops();
        send(CMD_WRITE_PIXEL, 0, 0, 24'hFFFFFF);
        send(CMD_REFRESH, 0, 1, 24'h000000);
        send(CMD_WRITE_BG, 127, 63, 24'hFFFFFF);
        send(CMD_REFRESH, 127, 62, 24'h000000);
        send(CMD_REMOVE, 127, 63, 24'h000000);
        send(CMD_WRITE_PIXEL, 127, 62, 24'hFFFFFF);
        send(CMD_REFRESH, 127, 62, 24'h000000);
        send(CMD_REMOVE, 0, 0, 24'hFFFFFF);
        send(CMD_REFRESH, 0, 0, 24'h000000);
    endtask

    task automatic test_screen_edges();
        set_screen(8'd1, 8'd1);
        send(CMD_WRITE_PIXEL, 0, 0, 24'h00FF00);
        send(CMD_REFRESH, 0, 1, 24'h000000);
        send(CMD_WRITE_PIXEL, 0, 1, 24'hFF0000);
        send(CMD_WRITE_PIXEL, 1, 0, 24'h0000FF);
        set_screen(8'd128, 8'd3);
        send(CMD_WRITE_PIXEL, 5, 2, 24'hAA55AA);
        send(CMD_REFRESH, 5, 3, 24'h000000);
        set_screen(8'd0, 8'd0);
        send(CMD_REFRESH, 3, 4, 24'h000000);
        send(CMD_WRITE_PIXEL, 3, 4, 24'h123456);
        set_screen(8'd255, 8'd255);
        send(CMD_REFRESH, 3, 4, 24'h000000);
        set_screen(8'd128, 8'd64);
        send(CMD_REFRESH, 5, 2, 24'h000000);
    endtask

    task automatic test_backpressure();
        int i;
        set_screen(8'd128, 8'd64);
        src_idle = 1'b0;
        hold_cycles = 300;
        for (i = 0; i < 20; i++)
        begin
            send(CMD_WRITE_PIXEL, 64 + i, 2 * i, palette[i % 4]);
            send(CMD_REFRESH, 64 + i, 2 * i + 1, 24'h000000);
        end
        drain_cells();
        src_idle = 1'b1;
    endtask

    task automatic random_phase(logic [7:0] cols, logic [7:0] rows, int want);
        int       useful;
        int       tries;
        int       pick;
        int       mode;
        logic [1:0] c;
        pixel_t   colour;
        bit       touched;
        useful = 0;
        tries = 0;
        set_screen(cols, rows);
        src_idle = ($urandom_range(0, 2) != 0);
        sink_idle = ($urandom_range(0, 2) != 0);
        while (useful < want && tries < 4 * want)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                c = CMD_WRITE_PIXEL;
            else if (pick < 45)
                c = CMD_WRITE_BG;
            else if (pick < 60)
                c = CMD_REMOVE;
            else
                c = CMD_REFRESH;
            pick = $urandom_range(0, 9);
            mode = (pick < 5) ? 0 : (pick < 9) ? 1 : 2;
            colour = ($urandom_range(0, 1) != 0) ? palette[$urandom_range(0, 3)]
                                                 : pixel_t'($urandom);
            send_item(c, pick_coord(act_cols, SCREEN_COLS, 6, mode),
                      pick_coord(act_rows, SCREEN_ROWS, 6, mode), colour, touched);
            if (touched)
                useful++;
            tries++;
            if ($urandom_range(0, 59) == 0)
                drain_cells();
        end
    endtask

    task automatic test_random();
        logic [7:0] cols_set [8] = '{8'd128, 8'd1, 8'd37, 8'd128, 8'd255, 8'd3, 8'd90, 8'd128};
        logic [7:0] rows_set [8] = '{8'd64, 8'd2, 8'd13, 8'd1, 8'd255, 8'd64, 8'd33, 8'd192};
        int i;
        for (i = 0; i < 8; i++)
            random_phase(cols_set[i], rows_set[i], 90);
    endtask

    initial
    begin
        int i;
        for (i = 0; i < FRAME_DEPTH; i++)
        begin
            frame_px[i] = '0;
            frame_bg[i] = '0;
            frame_mark[i] = 1'b1;
        end
        act_cols = ACTIVE_COLS_RESET;
        act_rows = ACTIVE_ROWS_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_pixel_ops();
        test_screen_edges();
        test_backpressure();
        test_random();

        drain_cells();
        repeat (20) @(posedge clk);
        $display("ran %0d items over %0d screen settings, %0d cell pairs compared",
                 items_sent, screens_set, cells_seen);
        $display("%0d field mismatches, %0d cell pairs never seen",
                 bad_fields, due_cells.size());
        if (bad_fields == 0 && due_cells.size() == 0)
            $display("[dirty_cell_framebuffer] OK");
        else
            $display("[dirty_cell_framebuffer] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/dcf_pkg.sv
src/dcf_ram.sv
src/dcf_modify.sv
src/dirty_cell_framebuffer.sv
test/tb.sv
